// ----- sv/le3_pkg.sv -----
// Shared constants, payload types and helpers for the 3x3x3 label erosion stream.
package le3_pkg;

   localparam int MAX_X_DEFAULT = 128;
   localparam int MAX_Y_DEFAULT = 128;
   localparam int MAX_Z_DEFAULT = 128;

   localparam int LABEL_W     = 8;
   localparam int DIM_W       = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   localparam logic [DIM_W-1:0] DIM_RESET = 8'd128;

   localparam int TAP_N       = 3;
   localparam int COL_W       = TAP_N * LABEL_W;
   localparam int SLAB_N      = TAP_N * TAP_N;
   localparam int SLAB_W      = TAP_N * COL_W;
   localparam int CENTER_TAP  = 1;
   localparam int CENTER_ELEM = 4;

   localparam int FIFO_DEPTH  = 8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DIM_X = 2'd0,
      CSR_DIM_Y = 2'd1,
      CSR_DIM_Z = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [LABEL_W-1:0] voxel_label;
      logic               flush;
   } req_type;

   typedef struct packed {
      logic [LABEL_W-1:0] eroded_label;
      logic               last_voxel;
   } rsp_type;

   typedef struct packed {
      logic store;
      logic emit;
      logic interior;
      logic last;
   } tag_type;

   function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] value,
                                             input int unsigned limit);
      int unsigned result;
      if (value == '0) begin
         result = 1;
      end else if (int'(value) > limit) begin
         result = limit;
      end else begin
         result = int'(value);
      end
      return result;
   endfunction

endpackage

// ----- sv/le3_stream_if.sv -----
// Valid/ready stream channel carrying one payload beat per handshake.
interface le3_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- sv/le3_tap_mem.sv -----
// Read-modify-write line memory keeping the two previous values of each entry.
module le3_tap_mem #(
   parameter int DEPTH = le3_pkg::MAX_Z_DEFAULT,
   parameter int WIDTH = le3_pkg::LABEL_W,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_en,
   input  logic [AW-1:0]                     in_addr,
   input  logic [WIDTH-1:0]                  in_data,
   output logic [le3_pkg::TAP_N*WIDTH-1:0]   taps
);

   localparam int SW = (le3_pkg::TAP_N - 1) * WIDTH;

   logic [SW-1:0]    mem [DEPTH];
   logic             en_ff;
   logic [AW-1:0]    addr_ff;
   logic [WIDTH-1:0] data_ff;
   logic [SW-1:0]    rd_ff;
   logic [SW-1:0]    wr_data;
   logic             bypass;

   assign wr_data = {rd_ff[SW-WIDTH-1:0], data_ff};
   assign bypass  = en_ff && (addr_ff == in_addr);
   assign taps    = {rd_ff, data_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff <= 1'b0;
      end else begin
         en_ff <= in_en;
      end
   end

   always_ff @(posedge clock) begin
      if (in_en) begin
         addr_ff <= in_addr;
         data_ff <= in_data;
      end
   end

   // write back the shifted entry
   always_ff @(posedge clock) begin
      if (en_ff) begin
         mem[addr_ff] <= wr_data;
      end
   end

   // forward the pending write when the next beat hits the same entry
   always_ff @(posedge clock) begin
      if (in_en) begin
         rd_ff <= bypass ? wr_data : mem[in_addr];
      end
   end

endmodule

// ----- sv/le3_window.sv -----
// Three-slab z window and the 27-neighbor erosion test.
module le3_window (
   input  logic                          clock,
   input  logic                          shift_en,
   input  logic [le3_pkg::SLAB_W-1:0]    slab,
   output logic [le3_pkg::LABEL_W-1:0]   eroded
);

   localparam int LW = le3_pkg::LABEL_W;

   logic [le3_pkg::SLAB_W-1:0] win_ff [le3_pkg::TAP_N];
   logic                       all_set;
   logic [LW-1:0]              center;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         win_ff[0] <= slab;
         for (int i = 1; i < le3_pkg::TAP_N; i++) begin
            win_ff[i] <= win_ff[i-1];
         end
      end
   end

   always_comb begin
      all_set = 1'b1;
      for (int i = 0; i < le3_pkg::TAP_N; i++) begin
         for (int j = 0; j < le3_pkg::SLAB_N; j++) begin
            if (win_ff[i][j*LW +: LW] == '0) begin
               all_set = 1'b0;
            end
         end
      end
      center = win_ff[le3_pkg::CENTER_TAP][le3_pkg::CENTER_ELEM*LW +: LW];
      eroded = all_set ? center : '0;
   end

endmodule

// ----- sv/le3_out_fifo.sv -----
// Result queue between the erosion pipeline and the response channel.
module le3_out_fifo (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       push_en,
   input  le3_pkg::rsp_type                           push_data,
   output logic                                       out_valid,
   input  logic                                       out_ready,
   output le3_pkg::rsp_type                           out_data,
   output logic [$clog2(le3_pkg::FIFO_DEPTH+1)-1:0]   count
);

   localparam int DEPTH = le3_pkg::FIFO_DEPTH;
   localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);

   le3_pkg::rsp_type entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff;
   logic [PW-1:0]    rd_ptr_ff;
   logic [CW-1:0]    count_ff;
   logic             pop;

   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push_en) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_en) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
         end
         count_ff <= count_ff + CW'(push_en) - CW'(pop);
      end
   end

endmodule

// ----- sv/label_erosion_3d_stream.sv -----
// Top level of the streaming 3x3x3 label erosion block.
//
//  channel  dir  handshake                  payload
//  req_ch   in   req_ch.valid/ready         voxel_label[7:0], flush
//  rsp_ch   out  rsp_ch.valid/ready         eroded_label[7:0], last_voxel
//  csr      in   csr_write_en               csr_index[1:0], csr_write_data[7:0]
//
// One beat per cycle in both directions unless stalled; the beat that releases a result
// sends it through plane memory read, row memory read, window shift and result queue.
// The plane memory holds MAX_Y*MAX_Z two-voxel columns, the row memory MAX_Z
// two-column slabs; neither is cleared.
// Reset and every register write also hold req_ch.ready low in the cycle after them.
// Input is also stalled when the 8-entry result queue plus beats in flight is full.
module label_erosion_3d_stream #(
   parameter int MAX_X = le3_pkg::MAX_X_DEFAULT,
   parameter int MAX_Y = le3_pkg::MAX_Y_DEFAULT,
   parameter int MAX_Z = le3_pkg::MAX_Z_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   le3_stream_if.sink                          req_ch,
   le3_stream_if.source                        rsp_ch,
   input  logic                                csr_write_en,
   input  logic [le3_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [le3_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   localparam int XW          = $clog2(MAX_X + 1);
   localparam int YW          = $clog2(MAX_Y + 1);
   localparam int ZW          = $clog2(MAX_Z + 1);
   localparam int PLANE_DEPTH = MAX_Y * MAX_Z;
   localparam int PAW         = (PLANE_DEPTH > 1) ? $clog2(PLANE_DEPTH) : 1;
   localparam int ZAW         = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
   localparam int LW          = $clog2(MAX_Y * MAX_Z + MAX_Z + 3);
   localparam int FCW         = $clog2(le3_pkg::FIFO_DEPTH + 1);

   logic [XW-1:0]  ex_ff;
   logic [YW-1:0]  ey_ff;
   logic [ZW-1:0]  ez_ff;
   logic [LW-1:0]  lag_ff;
   logic           settle_ff;

   logic [XW-1:0]  xi_ff, xi_in;
   logic [YW-1:0]  yi_ff, yi_in;
   logic [ZW-1:0]  zi_ff, zi_in;
   logic [PAW-1:0] pa_ff, pa_in;
   logic           in_done_ff, in_done_in;
   logic [XW-1:0]  xo_ff, xo_in;
   logic [YW-1:0]  yo_ff, yo_in;
   logic [ZW-1:0]  zo_ff, zo_in;
   logic [LW-1:0]  d_ff, d_in;

   logic           req_fire;
   logic           csr_hit;
   logic           store;
   logic           in_last;
   logic           out_last;
   logic           interior;
   logic           emit;
   logic [LW-1:0]  d_plus;

   le3_pkg::tag_type     s1_ff, s2_ff, s3_ff, s0_tag;
   logic [ZAW-1:0]       s1_zaddr_ff;

   logic [le3_pkg::COL_W-1:0]   column;
   logic [le3_pkg::SLAB_W-1:0]  slab;
   logic [le3_pkg::LABEL_W-1:0] eroded;
   le3_pkg::rsp_type            result;
   logic [FCW-1:0]              fifo_count;
   logic [FCW:0]                occupancy;

   // register file

   always_comb begin
      csr_hit = 1'b0;
      if (csr_write_en) begin
         unique case (csr_index)
            le3_pkg::CSR_DIM_X,
            le3_pkg::CSR_DIM_Y,
            le3_pkg::CSR_DIM_Z: csr_hit = 1'b1;
            default:            csr_hit = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_ff     <= XW'(le3_pkg::clamp_dim(le3_pkg::DIM_RESET, MAX_X));
         ey_ff     <= YW'(le3_pkg::clamp_dim(le3_pkg::DIM_RESET, MAX_Y));
         ez_ff     <= ZW'(le3_pkg::clamp_dim(le3_pkg::DIM_RESET, MAX_Z));
         settle_ff <= 1'b1;
      end else begin
         settle_ff <= csr_write_en;
         if (csr_write_en) begin
            unique case (csr_index)
               le3_pkg::CSR_DIM_X: ex_ff <= XW'(le3_pkg::clamp_dim(csr_write_data, MAX_X));
               le3_pkg::CSR_DIM_Y: ey_ff <= YW'(le3_pkg::clamp_dim(csr_write_data, MAX_Y));
               le3_pkg::CSR_DIM_Z: ez_ff <= ZW'(le3_pkg::clamp_dim(csr_write_data, MAX_Z));
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      lag_ff <= LW'(ey_ff) * LW'(ez_ff) + LW'(ez_ff) + LW'(1);
   end

   // position tracking

   assign occupancy     = (FCW+1)'(fifo_count) + (FCW+1)'(s1_ff.emit)
                        + (FCW+1)'(s2_ff.emit) + (FCW+1)'(s3_ff.emit);
   assign req_ch.ready  = !settle_ff && (occupancy < (FCW+1)'(le3_pkg::FIFO_DEPTH));
   assign req_fire      = req_ch.valid && req_ch.ready;

   assign store    = req_fire && !req_ch.payload.flush && !in_done_ff;
   assign in_last  = (xi_ff == ex_ff - XW'(1)) && (yi_ff == ey_ff - YW'(1))
                  && (zi_ff == ez_ff - ZW'(1));
   assign out_last = (xo_ff == ex_ff - XW'(1)) && (yo_ff == ey_ff - YW'(1))
                  && (zo_ff == ez_ff - ZW'(1));
   assign interior = (xo_ff != '0) && (yo_ff != '0) && (zo_ff != '0)
                  && (xo_ff != ex_ff - XW'(1)) && (yo_ff != ey_ff - YW'(1))
                  && (zo_ff != ez_ff - ZW'(1));
   assign in_done_in = in_done_ff || (store && in_last);
   assign d_plus     = d_ff + LW'(store);
   assign emit       = req_fire && (in_done_in || (d_plus > lag_ff));

   always_comb begin
      xi_in = xi_ff;
      yi_in = yi_ff;
      zi_in = zi_ff;
      pa_in = pa_ff;
      xo_in = xo_ff;
      yo_in = yo_ff;
      zo_in = zo_ff;
      d_in  = d_plus - LW'(emit);
      if (store) begin
         if (zi_ff == ez_ff - ZW'(1)) begin
            zi_in = '0;
            if (yi_ff == ey_ff - YW'(1)) begin
               yi_in = '0;
               pa_in = '0;
               xi_in = (xi_ff == ex_ff - XW'(1)) ? '0 : xi_ff + XW'(1);
            end else begin
               yi_in = yi_ff + YW'(1);
               pa_in = pa_ff + PAW'(1);
            end
         end else begin
            zi_in = zi_ff + ZW'(1);
            pa_in = pa_ff + PAW'(1);
         end
      end
      if (emit) begin
         if (zo_ff == ez_ff - ZW'(1)) begin
            zo_in = '0;
            if (yo_ff == ey_ff - YW'(1)) begin
               yo_in = '0;
               xo_in = (xo_ff == ex_ff - XW'(1)) ? '0 : xo_ff + XW'(1);
            end else begin
               yo_in = yo_ff + YW'(1);
            end
         end else begin
            zo_in = zo_ff + ZW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || csr_hit || (emit && out_last)) begin
         xi_ff      <= '0;
         yi_ff      <= '0;
         zi_ff      <= '0;
         pa_ff      <= '0;
         in_done_ff <= 1'b0;
         xo_ff      <= '0;
         yo_ff      <= '0;
         zo_ff      <= '0;
         d_ff       <= '0;
      end else begin
         xi_ff      <= xi_in;
         yi_ff      <= yi_in;
         zi_ff      <= zi_in;
         pa_ff      <= pa_in;
         in_done_ff <= in_done_in;
         xo_ff      <= xo_in;
         yo_ff      <= yo_in;
         zo_ff      <= zo_in;
         d_ff       <= d_in;
      end
   end

   // beat tags follow the memory pipeline

   always_comb begin
      s0_tag          = '0;
      s0_tag.store    = store;
      s0_tag.emit     = emit;
      s0_tag.interior = interior;
      s0_tag.last     = out_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
         s2_ff <= '0;
         s3_ff <= '0;
      end else begin
         s1_ff <= s0_tag;
         s2_ff <= s1_ff;
         s3_ff <= s2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (store) begin
         s1_zaddr_ff <= zi_ff[ZAW-1:0];
      end
   end

   le3_tap_mem #(
      .DEPTH (PLANE_DEPTH),
      .WIDTH (le3_pkg::LABEL_W)
   ) u_plane_mem (
      .clock   (clock),
      .reset   (reset),
      .in_en   (store),
      .in_addr (pa_ff),
      .in_data (req_ch.payload.voxel_label),
      .taps    (column)
   );

   le3_tap_mem #(
      .DEPTH (MAX_Z),
      .WIDTH (le3_pkg::COL_W)
   ) u_row_mem (
      .clock   (clock),
      .reset   (reset),
      .in_en   (s1_ff.store),
      .in_addr (s1_zaddr_ff),
      .in_data (column),
      .taps    (slab)
   );

   le3_window u_window (
      .clock    (clock),
      .shift_en (s2_ff.store),
      .slab     (slab),
      .eroded   (eroded)
   );

   always_comb begin
      result              = '0;
      result.eroded_label = s3_ff.interior ? eroded : '0;
      result.last_voxel   = s3_ff.last;
   end

   le3_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_en   (s3_ff.emit),
      .push_data (result),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (rsp_ch.payload),
      .count     (fifo_count)
   );

endmodule

// ----- sv/le3_checker.sv -----
// Port-level checks for the label erosion stream, bound to the top level.
module le3_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_ready,
   input logic                                csr_write_en,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input le3_pkg::rsp_type                    rsp_payload
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response beat changed while stalled");

   a_csr_stall: assert property (@(posedge clock) disable iff (reset)
      csr_write_en |=> !req_ready)
      else $error("request taken right after a register write");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response beat right after reset");

   a_last_border: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.last_voxel |-> rsp_payload.eroded_label == '0)
      else $error("final voxel lies on the border but kept its label");

endmodule

bind label_erosion_3d_stream le3_checker u_le3_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ch.ready),
   .csr_write_en (csr_write_en),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_payload  (rsp_ch.payload)
);
